// ===== rtl/quaternion_to_rotation_matrix_core_macros.svh =====
// Assertion helpers for the quaternion to rotation matrix core.
`ifndef QUATERNION_TO_ROTATION_MATRIX_CORE_MACROS_SVH
`define QUATERNION_TO_ROTATION_MATRIX_CORE_MACROS_SVH

// Same-cycle implication, off during reset.
`define QRM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("qrm assertion failed");

// Next-cycle implication, off during reset.
`define QRM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("qrm assertion failed");

`endif

// ===== rtl/qrm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package qrm_pkg;

  // Field and bus widths
  localparam int QUAT_W     = 16;
  localparam int IN_DATA_W  = 4 * QUAT_W;
  localparam int ENTRY_W    = 16;
  localparam int NUM_LANES  = 9;
  localparam int OUT_DATA_W = NUM_LANES * ENTRY_W;

  // Datapath widths: products, signed sums, divider words, quotient bits
  localparam int PROD_W = 2 * QUAT_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int DIV_W  = PROD_W + 1;
  localparam int QBITS  = ENTRY_W;

  // One in Q2.14
  localparam logic signed [ENTRY_W-1:0] Q_ONE_OUT = ENTRY_W'(16384);

  // Lanes on the diagonal (m00, m11, m22)
  localparam logic [NUM_LANES-1:0] DIAG_MASK = 9'b100010001;

  typedef logic [DIV_W-1:0] div_word_t;
  typedef div_word_t [NUM_LANES-1:0] lane_words_t;
  typedef logic [QBITS-1:0] quo_word_t;
  typedef quo_word_t [NUM_LANES-1:0] lane_quos_t;

  // Side information that rides along the divider
  typedef struct packed {
    logic [NUM_LANES-1:0] neg;
    logic                 zero;
  } div_tag_t;

endpackage

`default_nettype wire

// ===== rtl/qrm_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qrm_divider
  import qrm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        vld_i,
  input  wire div_word_t   den_i,
  input  wire lane_words_t mag_i,
  input  wire div_tag_t    tag_i,
  output logic             vld_o,
  output lane_quos_t       quo_o,
  output div_tag_t         tag_o
);

  // One restoring step per stage, nine lanes share the divisor
  lane_words_t rem_r   [QBITS];
  lane_words_t rem_nxt [QBITS];
  lane_quos_t  quo_r   [QBITS];
  lane_quos_t  quo_nxt [QBITS];
  div_word_t   den_r   [QBITS];
  div_tag_t    tag_r   [QBITS];
  logic [QBITS-1:0] vld_r;

  // Compare and subtract in every stage
  always_comb begin
    div_word_t trial;
    logic      ge;
    for (int l = 0; l < NUM_LANES; l++) begin
      trial = mag_i[l];
      ge    = (trial >= den_i);
      rem_nxt[0][l] = ge ? (trial - den_i) : trial;
      quo_nxt[0][l] = {{(QBITS-1){1'b0}}, ge};
    end
    for (int k = 1; k < QBITS; k++) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        trial = {rem_r[k-1][l][DIV_W-2:0], 1'b0};
        ge    = (trial >= den_r[k-1]);
        rem_nxt[k][l] = ge ? (trial - den_r[k-1]) : trial;
        quo_nxt[k][l] = {quo_r[k-1][l][QBITS-2:0], ge};
      end
    end
  end

  // Advance payload when the pipe moves
  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= den_i;
      tag_r[0] <= tag_i;
      for (int k = 0; k < QBITS; k++) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
      end
      for (int k = 1; k < QBITS; k++) begin
        den_r[k] <= den_r[k-1];
        tag_r[k] <= tag_r[k-1];
      end
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QBITS-2:0], vld_i};
    end
  end

  assign vld_o = vld_r[QBITS-1];
  assign quo_o = quo_r[QBITS-1];
  assign tag_o = tag_r[QBITS-1];

endmodule

`default_nettype wire

// ===== rtl/quaternion_to_rotation_matrix_core.sv =====
// Pipeline: products, norm and numerators, sign split, divider, then the rounding stage, each registered.
// Throughput: one beat per clock; the 16-stage divider pipeline takes a new item each cycle.
// The whole pipe holds while a result waits on out_tready; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "quaternion_to_rotation_matrix_core_macros.svh"

module quaternion_to_rotation_matrix_core
  import qrm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic [0:0]                 out_tuser   // zero_quat
);

  // Diagonal at minus one, all else zero
  localparam logic [OUT_DATA_W-1:0] ZERO_MATRIX = {16'hC000, 48'h0, 16'hC000, 48'h0, 16'hC000};
  localparam logic [QBITS-1:0] QUO_MAX = QBITS'(1) << (QBITS - 1);

  function automatic logic signed [SUM_W-1:0] ext(input logic signed [PROD_W-1:0] p);
    return SUM_W'(p);
  endfunction

  logic en;
  logic out_vld_r;

  // Move the whole pipe unless a result is held
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  // Input fields
  logic signed [QUAT_W-1:0] quat_w, quat_x, quat_y, quat_z;
  assign quat_w = $signed(in_tdata[0*QUAT_W +: QUAT_W]);
  assign quat_x = $signed(in_tdata[1*QUAT_W +: QUAT_W]);
  assign quat_y = $signed(in_tdata[2*QUAT_W +: QUAT_W]);
  assign quat_z = $signed(in_tdata[3*QUAT_W +: QUAT_W]);

  // Stage 1: the ten products
  logic signed [PROD_W-1:0] ww_r, xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic p1_vld_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ww_r <= PROD_W'(quat_w) * PROD_W'(quat_w);
      xx_r <= PROD_W'(quat_x) * PROD_W'(quat_x);
      yy_r <= PROD_W'(quat_y) * PROD_W'(quat_y);
      zz_r <= PROD_W'(quat_z) * PROD_W'(quat_z);
      xy_r <= PROD_W'(quat_x) * PROD_W'(quat_y);
      xz_r <= PROD_W'(quat_x) * PROD_W'(quat_z);
      yz_r <= PROD_W'(quat_y) * PROD_W'(quat_z);
      wx_r <= PROD_W'(quat_w) * PROD_W'(quat_x);
      wy_r <= PROD_W'(quat_w) * PROD_W'(quat_y);
      wz_r <= PROD_W'(quat_w) * PROD_W'(quat_z);
    end
  end

  // Stage 2: norm and the numerators, all scaled so that entry = num * 2^14 / n
  logic signed [SUM_W-1:0] n_nxt, n_r;
  logic signed [SUM_W-1:0] num_nxt [NUM_LANES];
  logic signed [SUM_W-1:0] num_r   [NUM_LANES];
  logic p2_vld_r;

  always_comb begin
    n_nxt      = ext(ww_r) + ext(xx_r) + ext(yy_r) + ext(zz_r);
    num_nxt[0] = ext(ww_r) + ext(xx_r) - ext(yy_r) - ext(zz_r);
    num_nxt[1] = (ext(xy_r) + ext(wz_r)) <<< 1;
    num_nxt[2] = (ext(xz_r) - ext(wy_r)) <<< 1;
    num_nxt[3] = (ext(xy_r) - ext(wz_r)) <<< 1;
    num_nxt[4] = ext(ww_r) - ext(xx_r) + ext(yy_r) - ext(zz_r);
    num_nxt[5] = (ext(yz_r) + ext(wx_r)) <<< 1;
    num_nxt[6] = (ext(xz_r) + ext(wy_r)) <<< 1;
    num_nxt[7] = (ext(yz_r) - ext(wx_r)) <<< 1;
    num_nxt[8] = ext(ww_r) - ext(xx_r) - ext(yy_r) + ext(zz_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r    <= n_nxt;
      num_r  <= num_nxt;
    end
  end

  // Stage 3: split sign and magnitude, flag the zero quaternion
  lane_words_t mag_nxt, mag_r;
  div_tag_t    tag_nxt, tag_r;
  div_word_t   den_r;
  logic        p3_vld_r;

  always_comb begin
    logic signed [SUM_W-1:0] absv;
    for (int l = 0; l < NUM_LANES; l++) begin
      tag_nxt.neg[l] = num_r[l][SUM_W-1];
      absv           = num_r[l][SUM_W-1] ? -num_r[l] : num_r[l];
      mag_nxt[l]     = absv[DIV_W-1:0];
    end
    tag_nxt.zero = (n_r == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
      tag_r <= tag_nxt;
      den_r <= n_r[DIV_W-1:0];
    end
  end

  // Front valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= in_tvalid;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
    end
  end

  // Stages 4 to 19: quotient with one extra bit for rounding
  logic       dv_vld;
  lane_quos_t dv_quo;
  div_tag_t   dv_tag;

  qrm_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (p3_vld_r),
    .den_i (den_r),
    .mag_i (mag_r),
    .tag_i (tag_r),
    .vld_o (dv_vld),
    .quo_o (dv_quo),
    .tag_o (dv_tag)
  );

  // Stage 20: round half away from zero, restore sign, override for zero input
  logic [OUT_DATA_W-1:0] out_data_nxt, out_data_r;
  logic                  out_zero_r;
  logic                  quo_ok;

  always_comb begin
    logic [QBITS:0]             q_rnd;
    logic signed [ENTRY_W-1:0]  ent;
    quo_ok = 1'b1;
    for (int l = 0; l < NUM_LANES; l++) begin
      q_rnd = (QBITS+1)'(dv_quo[l]) + (QBITS+1)'(1);
      ent   = ENTRY_W'(q_rnd[QBITS:1]);
      if (dv_tag.neg[l]) begin
        ent = -ent;
      end
      if (dv_tag.zero) begin
        ent = DIAG_MASK[l] ? -Q_ONE_OUT : '0;
      end
      out_data_nxt[l*ENTRY_W +: ENTRY_W] = ent;
      if (dv_quo[l] > QUO_MAX) begin
        quo_ok = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
      out_zero_r <= dv_tag.zero;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_zero_r;

  // An accepted beat lands in the first stage
  `QRM_ASSERT_NEXT(a_accept_to_p1, clk, rst_n, in_tvalid && in_tready, p1_vld_r)
  // Quotient never exceeds one in the doubled scale for a nonzero input
  `QRM_ASSERT_NOW(a_quo_bound, clk, rst_n, dv_vld && !dv_tag.zero, quo_ok)
  // Zero quaternion always yields the fixed matrix
  `QRM_ASSERT_NOW(a_zero_matrix, clk, rst_n, out_tvalid && out_tuser[0], out_tdata == ZERO_MATRIX)

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import qrm_pkg::*;

  // One input beat: w, x, y, z from the lowest bits up
  typedef logic [3:0][QUAT_W-1:0] quat_t;

  // One result beat: nine matrix entries with the zero flag above them
  typedef struct packed {
    logic                              zero_quat;
    logic [NUM_LANES-1:0][ENTRY_W-1:0] m;
  } rotation_t;

  // Kinds of random quaternion
  typedef enum int {SHAPE_FULL, SHAPE_SMALL, SHAPE_DOMINANT, SHAPE_SPARSE, SHAPE_ZERO} shape_e;

  // Matrix entry positions, row-major
  localparam int M00 = 0, M01 = 1, M02 = 2, M10 = 3, M11 = 4;
  localparam int M12 = 5, M20 = 6, M21 = 7, M22 = 8;

  localparam longint TWO_Q14 = 32768;
  localparam int IDLE_MAX     = 14;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 3000;
  localparam int RANDOM_ITEMS = 1800;
  localparam int HOLD_AT_ITEM = 600;

  class rotation_scoreboard;
    rotation_t expected_q[$];
    int        errors;
    string     lane_name[NUM_LANES] = '{"m00", "m01", "m02", "m10", "m11", "m12",
                                        "m20", "m21", "m22"};

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Round num/den to nearest, ties away from zero, then clamp to 16 bits
    function logic [ENTRY_W-1:0] ratio_q14(longint num, longint den);
      longint mag, q;
      mag = (num < 0) ? -num : num;
      q = (2 * mag + den) / (2 * den);
      if (num < 0) q = -q;
      if (q > 32767) q = 32767;
      else if (q < -32768) q = -32768;
      return q[ENTRY_W-1:0];
    endfunction

    // Normalized rotation matrix of a quaternion, frame-change convention
    function rotation_t rotate(quat_t q);
      longint w, x, y, z, n;
      rotation_t r;
      w = $signed(q[0]);
      x = $signed(q[1]);
      y = $signed(q[2]);
      z = $signed(q[3]);
      n = w * w + x * x + y * y + z * z;
      r.zero_quat = (n == 0);
      if (n == 0) begin
        // Skip normalization: minus one on the diagonal, zero elsewhere
        r.m = '0;
        r.m[M00] = -Q_ONE_OUT;
        r.m[M11] = -Q_ONE_OUT;
        r.m[M22] = -Q_ONE_OUT;
        return r;
      end
      r.m[M00] = ratio_q14((w * w + x * x) * TWO_Q14 - n * Q_ONE_OUT, n);
      r.m[M01] = ratio_q14((x * y + w * z) * TWO_Q14, n);
      r.m[M02] = ratio_q14((x * z - w * y) * TWO_Q14, n);
      r.m[M10] = ratio_q14((x * y - w * z) * TWO_Q14, n);
      r.m[M11] = ratio_q14((w * w + y * y) * TWO_Q14 - n * Q_ONE_OUT, n);
      r.m[M12] = ratio_q14((y * z + w * x) * TWO_Q14, n);
      r.m[M20] = ratio_q14((x * z + w * y) * TWO_Q14, n);
      r.m[M21] = ratio_q14((y * z - w * x) * TWO_Q14, n);
      r.m[M22] = ratio_q14((w * w + z * z) * TWO_Q14 - n * Q_ONE_OUT, n);
      return r;
    endfunction

    function void note_quat(quat_t q);
      expected_q.push_back(rotate(q));
    endfunction

    task check_result(rotation_t got);
      rotation_t want;
      if (expected_q.size() == 0) begin
        report("result beat with no input pending");
        return;
      end
      want = expected_q.pop_front();
      for (int i = 0; i < NUM_LANES; i++) begin
        if (got.m[i] !== want.m[i])
          report($sformatf("%s got %0d expected %0d", lane_name[i],
                           $signed(got.m[i]), $signed(want.m[i])));
      end
      if (got.zero_quat !== want.zero_quat)
        report($sformatf("zero_quat got %b expected %b", got.zero_quat, want.zero_quat));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // quat_w, quat_x, quat_y, quat_z
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // m00, m01, m02, m10, m11, m12, m20, m21, m22
  logic [0:0]            out_tuser;       // zero_quat

  rotation_scoreboard sb = new;
  int  sent = 0;
  bit  tx_quiet = 1'b0;
  bit  hold_req = 1'b0;
  int  idle_cycles = 0;

  quaternion_to_rotation_matrix_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predict on every accepted input beat, check every accepted result beat
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_quat(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result({out_tuser, out_tdata});
  end

  // End the run when neither side moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one quaternion after a random gap and hold it until accepted
  task automatic send_quat(int w, int x, int y, int z);
    int gap;
    if (sent % 64 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
    gap = tx_quiet ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {QUAT_W'(z), QUAT_W'(y), QUAT_W'(x), QUAT_W'(w)};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // Result side: random stalls per beat, one long hold when asked
  initial begin : result_sink
    int stall;
    int taken;
    bit rx_quiet;
    taken = 0;
    rx_quiet = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 64 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      stall = rx_quiet ? 0 : $urandom_range(0, IDLE_MAX);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  initial begin : stimulus
    int     part[4];
    shape_e shape;
    int     pick;
    int     lead;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Zero quaternion, each axis alone at an extreme (w and x at both), all-extreme mixes
    send_quat(0, 0, 0, 0);
    send_quat(32767, 0, 0, 0);
    send_quat(-32768, 0, 0, 0);
    send_quat(0, 32767, 0, 0);
    send_quat(0, 0, -32768, 0);
    send_quat(0, 0, 0, 32767);
    send_quat(0, -32768, 0, 0);
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(32767, -32768, 32767, -32768);
    send_quat(-32768, 32767, -32768, 32767);
    // Tiny norms where rounding ties and coarse ratios show up, then zero and mid-scale inputs
    send_quat(1, 0, 0, 0);
    send_quat(0, 0, 0, -1);
    send_quat(1, 1, 0, 0);
    send_quat(1, 1, 1, 1);
    send_quat(1, -1, 1, 0);
    send_quat(1, 2, 3, 4);
    send_quat(-3, 5, -7, 2);
    send_quat(0, 0, 0, 0);
    send_quat(23170, 23170, 0, 0);
    send_quat(16384, 16384, 16384, 16384);
    send_quat(-16384, 16384, -16384, 16384);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      pick = $urandom_range(0, 19);
      lead = $urandom_range(0, 3);
      if (pick < 10) shape = SHAPE_FULL;
      else if (pick < 14) shape = SHAPE_SMALL;
      else if (pick < 17) shape = SHAPE_DOMINANT;
      else if (pick < 19) shape = SHAPE_SPARSE;
      else shape = SHAPE_ZERO;
      for (int c = 0; c < 4; c++) begin
        case (shape)
          SHAPE_FULL:     part[c] = $urandom_range(0, 65535) - 32768;
          SHAPE_SMALL:    part[c] = $urandom_range(0, 16) - 8;
          SHAPE_DOMINANT: part[c] = (c == lead) ? $urandom_range(0, 65535) - 32768
                                                : $urandom_range(0, 16) - 8;
          SHAPE_SPARSE:   part[c] = $urandom_range(0, 1) ? $urandom_range(0, 65535) - 32768
                                                         : 0;
          default:        part[c] = 0;
        endcase
      end
      // Stall the result side for a long stretch so the pipe backs up
      if (k == HOLD_AT_ITEM) hold_req = 1'b1;
      send_quat(part[0], part[1], part[2], part[3]);
    end
    in_tvalid <= 1'b0;

    // Drain, then watch for stray beats
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/qrm_pkg.sv
rtl/qrm_divider.sv
rtl/quaternion_to_rotation_matrix_core.sv
bench/testbench.sv
